// ===== rtl/core/pms_pkg.sv =====
// Shared types, codes and constants of the passive motion sequencer.
package pms_pkg;

  // Field widths
  localparam int OPCODE_W = 1;
  localparam int RX_W     = 8;
  localparam int ANGLE_W  = 12;
  localparam int CMD_W    = 4;
  localparam int ARG_W    = 19;

  localparam int FRAME_BYTES     = 9;
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } pms_op_e;

  typedef enum logic [CMD_W-1:0] {
    CMD_STOP    = 4'd0,
    CMD_ENABLE  = 4'd1,
    CMD_ACCEL   = 4'd2,
    CMD_DECEL   = 4'd3,
    CMD_JERK    = 4'd4,
    CMD_JOG     = 4'd5,
    CMD_SPEED   = 4'd6,
    CMD_DISABLE = 4'd7,
    CMD_WAIT    = 4'd8
  } pms_cmd_e;

  typedef enum logic [2:0] {
    RS_IDLE  = 3'd0,
    RS_RUN   = 3'd1,
    RS_PAUSE = 3'd2,
    RS_STOP  = 3'd3,
    RS_EMERG = 3'd4
  } pms_run_e;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_ACTIVE  = 2'd1,
    MODE_PASSIVE = 2'd2
  } pms_mode_e;

  // Panel frame header and object ids
  localparam logic [RX_W-1:0] HDR_FIRST  = 8'h5A;
  localparam logic [RX_W-1:0] HDR_SECOND = 8'hA5;

  localparam logic [15:0] OBJ_SPEED  = 16'h1000;
  localparam logic [15:0] OBJ_TARGET = 16'h1001;
  localparam logic [15:0] OBJ_REPEAT = 16'h1002;
  localparam logic [15:0] OBJ_DWELL  = 16'h1003;
  localparam logic [15:0] OBJ_RUN    = 16'h3000;
  localparam logic [15:0] OBJ_MODE   = 16'h4000;

  // Data values of the run and mode objects
  localparam logic [RX_W-1:0] RUN_START = 8'd1;
  localparam logic [RX_W-1:0] RUN_PAUSE = 8'd2;
  localparam logic [RX_W-1:0] RUN_STOP  = 8'd3;
  localparam logic [RX_W-1:0] RUN_IDLE  = 8'd4;
  localparam logic [RX_W-1:0] RUN_EMERG = 8'd5;
  localparam logic [RX_W-1:0] MODE_SEL_ACTIVE  = 8'd1;
  localparam logic [RX_W-1:0] MODE_SEL_PASSIVE = 8'd2;

  // Fixed command sequence; a plan picks steps out of it by mask, lowest first.
  localparam int NUM_STEPS = 15;
  localparam int STEP_W    = $clog2(NUM_STEPS);
  typedef logic [STEP_W-1:0]    pms_step_t;
  typedef logic [NUM_STEPS-1:0] pms_mask_t;

  localparam pms_step_t STEP_RESTOP     = STEP_W'(0);   // stop
  localparam pms_step_t STEP_HOLD       = STEP_W'(1);   // wait 200 / 1000
  localparam pms_step_t STEP_ENABLE     = STEP_W'(2);   // enable / disable
  localparam pms_step_t STEP_SETTLE     = STEP_W'(3);   // wait 500
  localparam pms_step_t STEP_ACCEL      = STEP_W'(4);
  localparam pms_step_t STEP_DECEL      = STEP_W'(5);
  localparam pms_step_t STEP_JERK       = STEP_W'(6);
  localparam pms_step_t STEP_JOG        = STEP_W'(7);
  localparam pms_step_t STEP_SPEED      = STEP_W'(8);   // +speed / -2
  localparam pms_step_t STEP_TURN_STOP  = STEP_W'(9);
  localparam pms_step_t STEP_DWELL      = STEP_W'(10);
  localparam pms_step_t STEP_TURN_JOG   = STEP_W'(11);
  localparam pms_step_t STEP_TURN_SPEED = STEP_W'(12);
  localparam pms_step_t STEP_END_STOP   = STEP_W'(13);
  localparam pms_step_t STEP_PACE       = STEP_W'(14);  // wait 20

  // One tick's worth of commands, handed from front to back
  typedef struct packed {
    pms_mask_t       mask;
    logic            alt;       // stop/emergency variants of steps 1, 2, 8
    logic            turn_neg;  // turn speed is negative
    logic [RX_W-1:0] spd;
    logic [RX_W-1:0] dwell;
  } pms_plan_t;

endpackage

// ===== rtl/core/pms_front.sv =====
// Front end: frame receiver, settings and run state, per-tick command plan.
module pms_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [pms_pkg::OPCODE_W-1:0]  opcode_i,
  input  logic [pms_pkg::RX_W-1:0]      rx_byte_i,
  input  logic [pms_pkg::ANGLE_W-1:0]   encoder_angle_i,
  output logic                          push_o,
  output pms_pkg::pms_plan_t            plan_o
);
  import pms_pkg::*;

  localparam logic [3:0] FPOS_SYNC  = 4'd0;
  localparam logic [3:0] FPOS_HDR2  = 4'd1;
  localparam logic [3:0] FPOS_BODY  = 4'd2;
  localparam logic [3:0] FPOS_ID_HI = 4'd4;
  localparam logic [3:0] FPOS_ID_LO = 4'd5;
  localparam logic [3:0] FPOS_DATA  = 4'(FRAME_BYTES - 1);

  localparam logic [ANGLE_W-1:0] WRAP_LO = 12'd2701;
  localparam logic [ANGLE_W-1:0] WRAP_HI = 12'd3600;
  localparam logic [ANGLE_W-1:0] FAR_LO  = 12'd1501;
  localparam logic [ANGLE_W-1:0] FAR_HI  = 12'd2699;

  logic [3:0]      frame_pos_q, frame_pos_d;
  logic [RX_W-1:0] obj_hi_q, obj_hi_d, obj_lo_q, obj_lo_d;
  logic [RX_W-1:0] speed_q, speed_d, target_q, target_d;
  logic [RX_W-1:0] repeat_q, repeat_d, dwell_q, dwell_d;
  pms_run_e        run_state_q, run_state_d;
  pms_mode_e       mode_q, mode_d;
  logic            changed_q, changed_d, primed_q, primed_d;
  logic            heading_q, heading_d, homing_q, homing_d;
  logic [8:0]      cycles_q, cycles_d;

  always_comb begin
    logic [ANGLE_W-1:0] cur;
    logic [ANGLE_W-1:0] tgt;
    logic               primed;
    logic               heading;
    logic [8:0]         cl;

    frame_pos_d = frame_pos_q;
    obj_hi_d    = obj_hi_q;
    obj_lo_d    = obj_lo_q;
    speed_d     = speed_q;
    target_d    = target_q;
    repeat_d    = repeat_q;
    dwell_d     = dwell_q;
    run_state_d = run_state_q;
    mode_d      = mode_q;
    changed_d   = changed_q;
    primed_d    = primed_q;
    heading_d   = heading_q;
    homing_d    = homing_q;
    cycles_d    = cycles_q;

    plan_o          = '0;
    plan_o.spd      = speed_q;
    plan_o.dwell    = dwell_q;

    tgt = {4'd0, target_q} * 12'd10;
    cur = encoder_angle_i;
    if (encoder_angle_i inside {[WRAP_LO:WRAP_HI]}) begin
      cur = '0;
    end else if (encoder_angle_i inside {[FAR_LO:FAR_HI]}) begin
      cur = tgt;
    end
    primed  = primed_q & ~changed_q;
    heading = heading_q;
    cl      = cycles_q;

    if (accept_i && opcode_i == OP_BYTE) begin
      case (frame_pos_q)
        FPOS_SYNC: begin
          if (rx_byte_i == HDR_FIRST) frame_pos_d = FPOS_HDR2;
        end
        FPOS_HDR2: begin
          frame_pos_d = (rx_byte_i == HDR_SECOND) ? FPOS_BODY : FPOS_SYNC;
        end
        default: begin
          if (frame_pos_q == FPOS_ID_HI) obj_hi_d = rx_byte_i;
          if (frame_pos_q == FPOS_ID_LO) obj_lo_d = rx_byte_i;
          if (frame_pos_q == FPOS_DATA) begin
            frame_pos_d = FPOS_SYNC;
            case ({obj_hi_q, obj_lo_q})
              OBJ_SPEED:  speed_d  = rx_byte_i;
              OBJ_TARGET: target_d = rx_byte_i;
              OBJ_REPEAT: repeat_d = rx_byte_i;
              OBJ_DWELL:  dwell_d  = rx_byte_i;
              OBJ_RUN: begin
                case (rx_byte_i)
                  RUN_START: begin
                    run_state_d = RS_RUN;
                    changed_d   = 1'b1;
                  end
                  RUN_PAUSE: run_state_d = RS_PAUSE;
                  RUN_STOP: begin
                    run_state_d = RS_STOP;
                    homing_d    = 1'b0;
                  end
                  RUN_IDLE:  run_state_d = RS_IDLE;
                  RUN_EMERG: run_state_d = RS_EMERG;
                  default: ;
                endcase
              end
              OBJ_MODE: begin
                if (rx_byte_i == MODE_SEL_ACTIVE) mode_d = MODE_ACTIVE;
                else if (rx_byte_i == MODE_SEL_PASSIVE) mode_d = MODE_PASSIVE;
              end
              default: ;
            endcase
          end else begin
            frame_pos_d = frame_pos_q + 4'd1;
          end
        end
      endcase
    end else if (accept_i && mode_q == MODE_ACTIVE) begin
      case (run_state_q)
        RS_RUN: begin
          if (changed_q) begin
            plan_o.mask[STEP_RESTOP] = 1'b1;
            plan_o.mask[STEP_HOLD]   = 1'b1;
          end
          changed_d = 1'b0;
          primed_d  = 1'b1;
          if (!primed) begin
            plan_o.mask[STEP_ENABLE] = 1'b1;
            plan_o.mask[STEP_SETTLE] = 1'b1;
            plan_o.mask[STEP_ACCEL]  = 1'b1;
            plan_o.mask[STEP_DECEL]  = 1'b1;
            plan_o.mask[STEP_JERK]   = 1'b1;
            plan_o.mask[STEP_JOG]    = 1'b1;
            plan_o.mask[STEP_SPEED]  = 1'b1;
            cl      = {1'b0, repeat_q};
            heading = 1'b1;
          end
          heading_d = heading;
          if (heading && cur >= tgt) begin
            plan_o.mask[STEP_TURN_STOP]  = 1'b1;
            plan_o.mask[STEP_DWELL]      = 1'b1;
            plan_o.mask[STEP_TURN_JOG]   = 1'b1;
            plan_o.mask[STEP_TURN_SPEED] = 1'b1;
            plan_o.turn_neg = 1'b1;
            heading_d       = 1'b0;
          end else if (!heading && cur == '0) begin
            if (cl <= 9'd1) begin
              // repeats used up: park and end the run
              cl = '0;
              plan_o.mask[STEP_END_STOP] = 1'b1;
              run_state_d = RS_IDLE;
              primed_d    = 1'b0;
            end else begin
              cl = cl - 9'd1;
              plan_o.mask[STEP_TURN_STOP]  = 1'b1;
              plan_o.mask[STEP_DWELL]      = 1'b1;
              plan_o.mask[STEP_TURN_JOG]   = 1'b1;
              plan_o.mask[STEP_TURN_SPEED] = 1'b1;
              heading_d = 1'b1;
            end
          end
          cycles_d = cl;
          plan_o.mask[STEP_PACE] = 1'b1;
        end
        RS_PAUSE, RS_IDLE: plan_o.mask[STEP_RESTOP] = 1'b1;
        RS_STOP: begin
          plan_o.alt = 1'b1;
          if (!homing_q) begin
            plan_o.mask[STEP_RESTOP] = 1'b1;
            plan_o.mask[STEP_HOLD]   = 1'b1;
            if (encoder_angle_i == '0) begin
              heading_d   = 1'b1;
              run_state_d = RS_IDLE;
            end else begin
              plan_o.mask[STEP_JERK]  = 1'b1;
              plan_o.mask[STEP_JOG]   = 1'b1;
              plan_o.mask[STEP_SPEED] = 1'b1;
              heading_d = 1'b0;
            end
            homing_d = 1'b1;
          end else if (encoder_angle_i == '0) begin
            plan_o.mask[STEP_RESTOP] = 1'b1;
            heading_d   = 1'b1;
            run_state_d = RS_IDLE;
          end
        end
        RS_EMERG: begin
          plan_o.alt = 1'b1;
          plan_o.mask[STEP_RESTOP] = 1'b1;
          plan_o.mask[STEP_ENABLE] = 1'b1;
        end
        default: ;
      endcase
    end
    push_o = |plan_o.mask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_pos_q <= FPOS_SYNC;
      obj_hi_q    <= '0;
      obj_lo_q    <= '0;
      speed_q     <= 8'd1;
      target_q    <= 8'd10;
      repeat_q    <= 8'd10;
      dwell_q     <= 8'd1;
      run_state_q <= RS_IDLE;
      mode_q      <= MODE_ACTIVE;
      changed_q   <= 1'b0;
      primed_q    <= 1'b0;
      heading_q   <= 1'b1;
      homing_q    <= 1'b0;
      cycles_q    <= '0;
    end else begin
      frame_pos_q <= frame_pos_d;
      obj_hi_q    <= obj_hi_d;
      obj_lo_q    <= obj_lo_d;
      speed_q     <= speed_d;
      target_q    <= target_d;
      repeat_q    <= repeat_d;
      dwell_q     <= dwell_d;
      run_state_q <= run_state_d;
      mode_q      <= mode_d;
      changed_q   <= changed_d;
      primed_q    <= primed_d;
      heading_q   <= heading_d;
      homing_q    <= homing_d;
      cycles_q    <= cycles_d;
    end
  end

endmodule

// ===== rtl/core/pms_queue.sv =====
// Plan queue between front end and command sequencer.
module pms_queue #(
  parameter int DEPTH = pms_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pms_pkg::pms_plan_t push_plan_i,
  output logic               full_o,
  output logic               head_valid_o,
  output pms_pkg::pms_plan_t head_plan_o,
  input  logic               pop_i
);
  import pms_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  pms_plan_t        entries_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o       = (count_q == CNT_W'(DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_plan_o  = entries_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) count_d = count_q + CNT_W'(1);
    else if (do_pop && !do_push) count_d = count_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entries_q[wr_ptr_q] <= push_plan_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== rtl/core/pms_back.sv =====
// Back end: walks a plan's step mask, one command per cycle unless stalled.
module pms_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         head_valid_i,
  input  pms_pkg::pms_plan_t           head_plan_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [pms_pkg::CMD_W-1:0]    motor_command_o,
  output logic [pms_pkg::ARG_W-1:0]    argument_o,
  output logic                         last_of_tick_o
);
  import pms_pkg::*;

  localparam logic [ARG_W-1:0] ARG_ZERO      = 19'd0;
  localparam logic [ARG_W-1:0] ARG_RESTART   = 19'd200;
  localparam logic [ARG_W-1:0] ARG_HOME_WAIT = 19'd1000;
  localparam logic [ARG_W-1:0] ARG_SETTLE    = 19'd500;
  localparam logic [ARG_W-1:0] ARG_RAMP      = 19'd10;
  localparam logic [ARG_W-1:0] ARG_JERK      = 19'd1;
  localparam logic [ARG_W-1:0] ARG_PACE      = 19'd20;
  localparam logic [ARG_W-1:0] ARG_HOME_SPD  = 19'h7FFFE;   // -2
  localparam logic [ARG_W-1:0] MS_PER_S      = 19'd1000;

  pms_plan_t        cur_q, cur_d;
  logic             valid_q, valid_d, last_q, last_d;
  logic [CMD_W-1:0] cmd_q, cmd_d;
  logic [ARG_W-1:0] arg_q, arg_d;

  logic             advance, emit, load;
  pms_mask_t        low, rest;
  pms_step_t        idx;
  pms_cmd_e         cmd;
  logic [ARG_W-1:0] arg, spd_pos, spd_neg, dwell_ms;

  // lowest pending step
  always_comb begin
    low = cur_q.mask & (~cur_q.mask + NUM_STEPS'(1));
    idx = '0;
    for (int i = 0; i < NUM_STEPS; i++) begin
      if (low[i]) idx = idx | STEP_W'(i);
    end
    rest = cur_q.mask & ~low;
  end

  always_comb begin
    spd_pos  = {{(ARG_W-RX_W){1'b0}}, cur_q.spd};
    spd_neg  = ~spd_pos + ARG_W'(1);
    dwell_ms = {{(ARG_W-RX_W){1'b0}}, cur_q.dwell} * MS_PER_S;
    cmd = CMD_STOP;
    arg = ARG_ZERO;
    case (idx)
      STEP_RESTOP, STEP_TURN_STOP, STEP_END_STOP: cmd = CMD_STOP;
      STEP_HOLD: begin
        cmd = CMD_WAIT;
        arg = cur_q.alt ? ARG_HOME_WAIT : ARG_RESTART;
      end
      STEP_ENABLE: cmd = cur_q.alt ? CMD_DISABLE : CMD_ENABLE;
      STEP_SETTLE: begin
        cmd = CMD_WAIT;
        arg = ARG_SETTLE;
      end
      STEP_ACCEL: begin
        cmd = CMD_ACCEL;
        arg = ARG_RAMP;
      end
      STEP_DECEL: begin
        cmd = CMD_DECEL;
        arg = ARG_RAMP;
      end
      STEP_JERK: begin
        cmd = CMD_JERK;
        arg = ARG_JERK;
      end
      STEP_JOG, STEP_TURN_JOG: cmd = CMD_JOG;
      STEP_SPEED: begin
        cmd = CMD_SPEED;
        arg = cur_q.alt ? ARG_HOME_SPD : spd_pos;
      end
      STEP_DWELL: begin
        cmd = CMD_WAIT;
        arg = dwell_ms;
      end
      STEP_TURN_SPEED: begin
        cmd = CMD_SPEED;
        arg = cur_q.turn_neg ? spd_neg : spd_pos;
      end
      STEP_PACE: begin
        cmd = CMD_WAIT;
        arg = ARG_PACE;
      end
      default: ;
    endcase
  end

  always_comb begin
    advance = !valid_q || !out_stall_i;
    emit    = advance && (cur_q.mask != '0);
    // refill when idle, or in the same cycle as a plan's final command
    load    = (cur_q.mask == '0) || (emit && rest == '0);
    pop_o   = head_valid_i && load;

    cur_d   = cur_q;
    valid_d = valid_q;
    cmd_d   = cmd_q;
    arg_d   = arg_q;
    last_d  = last_q;
    if (emit) cur_d.mask = rest;
    if (pop_o) cur_d = head_plan_i;
    if (advance) valid_d = emit;
    if (emit) begin
      cmd_d  = cmd;
      arg_d  = arg;
      last_d = (rest == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      cur_q   <= cur_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    arg_q  <= arg_d;
    last_q <= last_d;
  end

  assign out_valid_o     = valid_q;
  assign motor_command_o = cmd_q;
  assign argument_o      = arg_q;
  assign last_of_tick_o  = last_q;

endmodule

// ===== rtl/core/passive_motion_sequencer_top.sv =====
// Top level of the passive motion sequencer: front end, plan queue, back end.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------------
//   input   | in        | in_valid_i / in_stall_o | opcode_i, rx_byte_i, encoder_angle_i
//   output  | out       | out_valid_o / out_stall_i | motor_command_o, argument_o,
//           |           |                        | last_of_tick_o
//
// When a request is taken, the front end updates its settings and run state
// at that edge and queues a tick's command plan, if the tick yields one.
// The back end issues a plan's 1 to 14 commands one per cycle unless stalled,
// via the queue, its plan and output registers; back-to-back plans have no gap.
// in_stall_o is high while the plan queue holds QUEUE_DEPTH plans.
// Reset is asynchronous, active low, and leaves the queue and output empty.
module passive_motion_sequencer_top #(
  parameter int QUEUE_DEPTH = pms_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [pms_pkg::OPCODE_W-1:0]       opcode_i,
  input  logic [pms_pkg::RX_W-1:0]           rx_byte_i,
  input  logic [pms_pkg::ANGLE_W-1:0]        encoder_angle_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [pms_pkg::CMD_W-1:0]          motor_command_o,
  output logic signed [pms_pkg::ARG_W-1:0]   argument_o,
  output logic                               last_of_tick_o
);
  import pms_pkg::*;

  logic             accept, push, full, head_valid, pop;
  pms_plan_t        push_plan, head_plan;
  logic [ARG_W-1:0] arg;

  assign accept     = in_valid_i && !full;
  assign in_stall_o = full;
  assign argument_o = $signed(arg);

  pms_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .opcode_i        (opcode_i),
    .rx_byte_i       (rx_byte_i),
    .encoder_angle_i (encoder_angle_i),
    .push_o          (push),
    .plan_o          (push_plan)
  );

  pms_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_plan_i  (push_plan),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_plan_o  (head_plan),
    .pop_i        (pop)
  );

  pms_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_plan_i     (head_plan),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .motor_command_o (motor_command_o),
    .argument_o      (arg),
    .last_of_tick_o  (last_of_tick_o)
  );

endmodule

// ===== rtl/core/pms_checker.sv =====
// Port-level assertions for the passive motion sequencer, bound to the top level.
module pms_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_stall_o,
  input  logic [pms_pkg::OPCODE_W-1:0]       opcode_i,
  input  logic [pms_pkg::RX_W-1:0]           rx_byte_i,
  input  logic [pms_pkg::ANGLE_W-1:0]        encoder_angle_i,
  input  logic                               out_valid_o,
  input  logic                               out_stall_i,
  input  logic [pms_pkg::CMD_W-1:0]          motor_command_o,
  input  logic signed [pms_pkg::ARG_W-1:0]   argument_o,
  input  logic                               last_of_tick_o
);
  import pms_pkg::*;

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(motor_command_o)
      && $stable(argument_o) && $stable(last_of_tick_o))
    else $error("stalled result changed");

  // disable only closes an emergency tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && motor_command_o == CMD_DISABLE |-> last_of_tick_o)
    else $error("disable not last of tick");

  // a closing wait is the pacing wait or the homing wait
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_tick_o && motor_command_o == CMD_WAIT
      |-> argument_o == 19'sd20 || argument_o == 19'sd1000)
    else $error("unexpected closing wait");

  // commands without a value carry zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (motor_command_o == CMD_STOP || motor_command_o == CMD_ENABLE
      || motor_command_o == CMD_JOG || motor_command_o == CMD_DISABLE)
      |-> argument_o == '0)
    else $error("nonzero argument on plain command");

endmodule

bind passive_motion_sequencer_top pms_checker u_checker (.*);

// ===== sim/tb_passive_motion_sequencer_top.sv =====
// Self-checking testbench for passive_motion_sequencer_top: panel frames, ticks, command checks.
module tb_passive_motion_sequencer_top;
  import pms_pkg::*;

  localparam int MAX_CMDS_PER_TICK = 14;
  localparam int RANDOM_ITEMS      = 400;
  localparam int DRAIN_PAD         = 16;
  localparam int HOLD_CYCLES       = 200;
  localparam int MAX_LOGGED        = 30;

  typedef struct {
    pms_cmd_e                cmd;
    logic signed [ARG_W-1:0] arg;
    logic                    last;
  } motor_cmd_t;

  class motion_scoreboard;
    logic [3:0]  frame_pos;
    logic [7:0]  obj_hi, obj_lo, speed, target, repeats, dwell;
    pms_run_e    run;
    pms_mode_e   mode;
    bit          changed, primed, outward, homing;
    logic [8:0]  laps_left;
    motor_cmd_t  tick_cmds[$];
    motor_cmd_t  expected_cmds[$];
    int          errors, commands_checked, ticks_taken, frames_applied, runs_completed;

    function new();
      frame_pos = '0;
      obj_hi    = '0;
      obj_lo    = '0;
      speed     = 8'd1;
      target    = 8'd10;
      repeats   = 8'd10;
      dwell     = 8'd1;
      run       = RS_IDLE;
      mode      = MODE_ACTIVE;
      changed   = 1'b0;
      primed    = 1'b0;
      outward   = 1'b1;
      homing    = 1'b0;
      laps_left = '0;
      errors = 0;
      commands_checked = 0;
      ticks_taken = 0;
      frames_applied = 0;
      runs_completed = 0;
    endfunction

    function void issue(pms_cmd_e cmd, int arg);
      motor_cmd_t c;
      if (tick_cmds.size() >= MAX_CMDS_PER_TICK) return;
      c.cmd  = cmd;
      c.arg  = ARG_W'(arg);
      c.last = 1'b0;
      tick_cmds.push_back(c);
    endfunction

    function void apply_panel_frame(logic [7:0] data);
      logic [15:0] id;
      id = {obj_hi, obj_lo};
      frames_applied++;
      case (id)
        OBJ_SPEED:  speed = data;
        OBJ_TARGET: target = data;
        OBJ_REPEAT: repeats = data;
        OBJ_DWELL:  dwell = data;
        OBJ_RUN: begin
          case (data)
            RUN_START: begin
              run = RS_RUN;
              changed = 1'b1;
            end
            RUN_PAUSE: run = RS_PAUSE;
            RUN_STOP: begin
              run = RS_STOP;
              homing = 1'b0;
            end
            RUN_IDLE:  run = RS_IDLE;
            RUN_EMERG: run = RS_EMERG;
            default: ;
          endcase
        end
        OBJ_MODE: begin
          if (data == MODE_SEL_ACTIVE) mode = MODE_ACTIVE;
          else if (data == MODE_SEL_PASSIVE) mode = MODE_PASSIVE;
        end
        default: ;
      endcase
    endfunction

    function void take_panel_byte(logic [7:0] b);
      if (frame_pos == 4'd0) begin
        if (b == HDR_FIRST) frame_pos = 4'd1;
      end else if (frame_pos == 4'd1) begin
        frame_pos = (b == HDR_SECOND) ? 4'd2 : 4'd0;
      end else begin
        if (frame_pos == 4'd4) obj_hi = b;
        if (frame_pos == 4'd5) obj_lo = b;
        frame_pos = frame_pos + 4'd1;
        if (frame_pos >= FRAME_BYTES) begin
          apply_panel_frame(b);
          frame_pos = 4'd0;
        end
      end
    endfunction

    function void running_tick(int raw);
      int cur, tgt, hold_ms, spd;
      cur     = raw;
      tgt     = target * 10;
      hold_ms = dwell * 1000;
      spd     = speed;
      // wrap zones: past 270 deg up to 360 reads as home, the middle band reads as target
      if (cur > 2700 && cur <= 3600) cur = 0;
      else if (cur > 1500 && cur < 2700) cur = tgt;
      if (changed) begin
        issue(CMD_STOP, 0);
        issue(CMD_WAIT, 200);
        primed  = 1'b0;
        changed = 1'b0;
      end
      if (!primed) begin
        issue(CMD_ENABLE, 0);
        issue(CMD_WAIT, 500);
        issue(CMD_ACCEL, 10);
        issue(CMD_DECEL, 10);
        issue(CMD_JERK, 1);
        issue(CMD_JOG, 0);
        laps_left = {1'b0, repeats};
        primed    = 1'b1;
        issue(CMD_SPEED, spd);
        outward = 1'b1;
      end
      if (outward && cur >= tgt) begin
        issue(CMD_STOP, 0);
        issue(CMD_WAIT, hold_ms);
        issue(CMD_JOG, 0);
        issue(CMD_SPEED, -spd);
        outward = 1'b0;
      end else if (!outward && cur == 0) begin
        if (laps_left <= 9'd1) begin
          laps_left = '0;
          issue(CMD_STOP, 0);
          run    = RS_IDLE;
          primed = 1'b0;
          runs_completed++;
        end else begin
          laps_left = laps_left - 9'd1;
          issue(CMD_STOP, 0);
          issue(CMD_WAIT, hold_ms);
          issue(CMD_JOG, 0);
          issue(CMD_SPEED, spd);
          outward = 1'b1;
        end
      end
      issue(CMD_WAIT, 20);
    endfunction

    // stop request: first tick brakes and waits, then creeps home at -2 unless already home
    function void homing_tick(int raw);
      if (!homing) begin
        issue(CMD_STOP, 0);
        issue(CMD_WAIT, 1000);
        if (raw == 0) begin
          outward = 1'b1;
          run     = RS_IDLE;
        end else begin
          issue(CMD_JERK, 1);
          issue(CMD_JOG, 0);
          issue(CMD_SPEED, -2);
          outward = 1'b0;
        end
        homing = 1'b1;
      end else if (raw == 0) begin
        issue(CMD_STOP, 0);
        outward = 1'b1;
        run     = RS_IDLE;
      end
    endfunction

    function void note_request(pms_op_e op, logic [7:0] b, logic [11:0] ang);
      if (op == OP_BYTE) begin
        take_panel_byte(b);
        return;
      end
      ticks_taken++;
      if (mode != MODE_ACTIVE) return;
      tick_cmds.delete();
      case (run)
        RS_RUN:            running_tick(ang);
        RS_PAUSE, RS_IDLE: issue(CMD_STOP, 0);
        RS_STOP:           homing_tick(ang);
        RS_EMERG: begin
          issue(CMD_STOP, 0);
          issue(CMD_DISABLE, 0);
        end
        default: ;
      endcase
      if (tick_cmds.size() > 0) tick_cmds[tick_cmds.size()-1].last = 1'b1;
      foreach (tick_cmds[i]) expected_cmds.push_back(tick_cmds[i]);
    endfunction

    task report(string msg);
      errors++;
      // keep the log short on a badly broken build
      if (errors <= MAX_LOGGED) $display("MISMATCH: %s", msg);
    endtask

    task check_result(logic [CMD_W-1:0] cmd, logic signed [ARG_W-1:0] arg, logic last);
      motor_cmd_t exp;
      if (expected_cmds.size() == 0) begin
        report($sformatf("unexpected command %0d arg %0d last %b", cmd, arg, last));
        return;
      end
      exp = expected_cmds.pop_front();
      commands_checked++;
      if (cmd !== exp.cmd || arg !== exp.arg || last !== exp.last)
        report($sformatf("got command %0d arg %0d last %b, wanted %s arg %0d last %b",
                         cmd, arg, last, exp.cmd.name(), exp.arg, exp.last));
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [OPCODE_W-1:0]     opcode = OP_BYTE;
  logic [RX_W-1:0]         rx_byte = '0;
  logic [ANGLE_W-1:0]      enc_angle = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [CMD_W-1:0]        motor_cmd;
  logic signed [ARG_W-1:0] cmd_arg;
  logic                    last_of_tick;

  motion_scoreboard sb = new();

  int burst_left = 0;
  int items_sent = 0;
  int input_stall_cycles = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  int hold_asked = 0;
  int hold_served = 0;

  passive_motion_sequencer_top uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .opcode_i        (opcode),
    .rx_byte_i       (rx_byte),
    .encoder_angle_i (enc_angle),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .motor_command_o (motor_cmd),
    .argument_o      (cmd_arg),
    .last_of_tick_o  (last_of_tick)
  );

  always #1 clk = ~clk;

  // signals read here hold their pre-edge values, as the block sees them
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_request(pms_op_e'(opcode), rx_byte, enc_angle);
      if (in_valid && in_stall) input_stall_cycles++;
      if (out_valid && !out_stall) sb.check_result(motor_cmd, cmd_arg, last_of_tick);
    end
  end

  // command sink: long hold-off on request, otherwise a changing stall pattern
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left   = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 9) < 7);
        default: out_stall <= ($urandom_range(0, 15) == 0) ? ~out_stall : out_stall;
      endcase
    end
  end

  task automatic send_request(pms_op_e op, logic [7:0] b, logic [11:0] ang);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid  <= 1'b1;
    opcode    <= op;
    rx_byte   <= b;
    enc_angle <= ang;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_request(OP_BYTE, b, 12'($urandom));
  endtask

  task automatic send_tick(logic [11:0] ang);
    send_request(OP_TICK, 8'($urandom), ang);
  endtask

  task automatic send_frame(logic [15:0] obj, logic [7:0] data);
    logic [7:0] frame_bytes [FRAME_BYTES];
    frame_bytes = '{HDR_FIRST, HDR_SECOND, 8'($urandom), 8'($urandom), obj[15:8], obj[7:0],
                    8'($urandom), 8'($urandom), data};
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    // let the monitor book the last accepted request first
    @(posedge clk);
    while (sb.expected_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
    burst_left = 0;
  endtask

  // angles biased toward home, the target and the zone edges
  function automatic logic [11:0] pick_angle();
    int tgt;
    tgt = sb.target * 10;
    case ($urandom_range(0, 9))
      0, 1: return 12'd0;
      2: return 12'(tgt);
      3: return 12'(tgt + $urandom_range(0, 20));
      4: return 12'($urandom_range(2701, 3600));
      5: return 12'($urandom_range(1501, 2699));
      6: return 12'd2700;
      7: return 12'($urandom_range(3601, 4095));
      default: return 12'($urandom);
    endcase
  endfunction

  task automatic send_random_frame();
    int pick, r;
    logic [7:0] data;
    pick = $urandom_range(0, 99);
    r    = $urandom_range(0, 9);
    if (pick < 40) begin
      if (r < 5) data = RUN_START;
      else if (r == 5) data = RUN_PAUSE;
      else if (r == 6) data = RUN_STOP;
      else if (r == 7) data = RUN_IDLE;
      else if (r == 8) data = RUN_EMERG;
      else data = 8'($urandom);
      send_frame(OBJ_RUN, data);
    end else if (pick < 55) begin
      send_frame(OBJ_TARGET, (r == 0) ? 8'($urandom) : 8'($urandom_range(0, 25)));
    end else if (pick < 65) begin
      send_frame(OBJ_REPEAT, (r == 0) ? 8'($urandom) : 8'($urandom_range(0, 4)));
    end else if (pick < 72) begin
      send_frame(OBJ_DWELL, 8'($urandom));
    end else if (pick < 80) begin
      send_frame(OBJ_SPEED, 8'($urandom));
    end else if (pick < 93) begin
      if (r < 6) data = MODE_SEL_ACTIVE;
      else if (r < 8) data = MODE_SEL_PASSIVE;
      else data = 8'($urandom);
      send_frame(OBJ_MODE, data);
    end else begin
      send_frame(16'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    int stop_at, hold_at, pause_at, pick;
    bit hold_done, pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: stray bytes, idle ticks, one short run, homing, emergency, passive mode
    send_byte(8'h00);
    send_byte(8'hFF);
    send_tick(12'd0);
    send_tick(12'hFFF);
    send_frame(OBJ_REPEAT, 8'd1);
    send_frame(OBJ_RUN, RUN_START);
    send_tick(12'd0);
    send_tick(12'hFFF);
    send_tick(12'd3000);          // wrap zone reads as home, last lap ends the run
    send_frame(OBJ_RUN, RUN_STOP);
    send_tick(12'd500);
    send_tick(12'd500);           // still homing: nothing issued
    send_tick(12'd0);
    send_frame(OBJ_RUN, RUN_STOP);
    send_tick(12'd0);             // already home after the brake wait
    send_frame(OBJ_TARGET, 8'd0);
    send_frame(OBJ_RUN, RUN_START);
    send_tick(12'd2700);          // full plan: restart, prime and turn at once
    send_frame(OBJ_RUN, RUN_EMERG);
    send_tick(12'd1234);
    send_frame(OBJ_MODE, MODE_SEL_PASSIVE);
    send_tick(12'd100);
    send_frame(OBJ_MODE, MODE_SEL_ACTIVE);
    wait_idle();

    stop_at  = items_sent + RANDOM_ITEMS;
    hold_at  = items_sent + 150;
    pause_at = items_sent + 320;
    while (items_sent < stop_at) begin
      if (!hold_done && items_sent >= hold_at) begin
        // finish any broken frame, then back up the plan queue while the sink holds off
        repeat (FRAME_BYTES) send_byte(8'h00);
        send_frame(OBJ_MODE, MODE_SEL_ACTIVE);
        send_frame(OBJ_RUN, RUN_START);
        hold_asked <= hold_asked + 1;
        repeat (12) send_tick(pick_angle());
        hold_done = 1'b1;
      end else if (!pause_done && items_sent >= pause_at) begin
        wait_idle();
        pause_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_random_frame();
      end else if (pick < 85) begin
        send_tick(pick_angle());
      end else if (pick < 93) begin
        // broken frames: doubled first header byte or a truncated body
        send_byte(HDR_FIRST);
        if ($urandom_range(0, 1) == 0) begin
          send_byte(HDR_FIRST);
        end else begin
          send_byte(HDR_SECOND);
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        end
      end else begin
        send_byte(8'($urandom));
      end
    end
    wait_idle();

    $display("run covered %0d requests: %0d ticks, %0d panel frames, %0d commands checked",
             items_sent, sb.ticks_taken, sb.frames_applied, sb.commands_checked);
    $display("%0d motion runs finished, input held off for %0d cycles",
             sb.runs_completed, input_stall_cycles);
    if (sb.errors == 0) $display("passive_motion_sequencer_top regression: pass");
    else $display("passive_motion_sequencer_top regression: fail");
    $finish;
  end

  initial begin
    #1000000;
    $display("timeout with %0d commands outstanding", sb.expected_cmds.size());
    $display("passive_motion_sequencer_top regression: fail");
    $finish;
  end

endmodule
